>>> hdl/quaternion_product_normalized_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the normalized quaternion product unit
// Same-cycle and next-cycle implication checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_PRODUCT_NORMALIZED_UNIT_ASSERT_SVH
`define QUATERNION_PRODUCT_NORMALIZED_UNIT_ASSERT_SVH

// Same-cycle implication check.
`define QPN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define QPN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/qpn_pkg.sv
// ----------------------------------------------------------------------------
// qpn_pkg
// Shared constants of the normalized quaternion product unit.
// ----------------------------------------------------------------------------
package qpn_pkg;

    localparam int FRAC_BITS_DEF  = 14;
    localparam int COMP_WIDTH_DEF = 16;
    localparam int NORM_GUARD     = 8;
    localparam int EPS_WIDTH      = 16;
    localparam int EPS_RESET      = 16;

endpackage

>>> hdl/qpn_isqrt.sv
// ----------------------------------------------------------------------------
// qpn_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qpn_isqrt #(
    parameter int DW = 30
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*DW-1:0] n_in,
    output logic [DW-1:0]   root_out
);

    localparam int RMW = DW + 3;

    logic [RMW-1:0]  rem_reg  [DW];
    logic [DW-1:0]   root_reg [DW];
    logic [2*DW-1:0] n_reg    [DW];

    for (genvar k = 0; k < DW; k++)
    begin : g_stage
        logic [RMW-1:0]  rem_p;
        logic [DW-1:0]   root_p;
        logic [2*DW-1:0] n_p;
        logic [RMW-1:0]  rem_sh;
        logic [RMW-1:0]  trial;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign n_p    = n_in;
        end
        else
        begin : g_rest
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign n_p    = n_reg[k-1];
        end

        assign rem_sh = {rem_p[DW:0], n_p[2*DW-1 -: 2]};
        assign trial  = {1'b0, root_p, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_p[DW-2:0], ge};
                n_reg[k]    <= n_p << 2;
            end
        end
    end

    assign root_out = root_reg[DW-1];

endmodule

>>> hdl/qpn_divide.sv
// ----------------------------------------------------------------------------
// qpn_divide
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qpn_divide #(
    parameter int NUMW = 47,
    parameter int DENW = 31,
    parameter int QOW  = 16
) (
    input  logic            clk,
    input  logic            en,
    input  logic [NUMW-1:0] num_in,
    input  logic [DENW-1:0] den_in,
    output logic [QOW-1:0]  quo_out
);

    logic [NUMW-1:0] num_reg [QOW];
    logic [DENW-1:0] den_reg [QOW];
    logic [QOW-1:0]  quo_reg [QOW];

    for (genvar k = 0; k < QOW; k++)
    begin : g_stage
        logic [NUMW-1:0] num_p;
        logic [DENW-1:0] den_p;
        logic [QOW-1:0]  quo_p;
        logic [NUMW-1:0] sh;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign num_p = num_in;
            assign den_p = den_in;
            assign quo_p = '0;
        end
        else
        begin : g_rest
            assign num_p = num_reg[k-1];
            assign den_p = den_reg[k-1];
            assign quo_p = quo_reg[k-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        assign sh = NUMW'(den_p) << (QOW - 1 - k);
        assign ge = (num_p >= sh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k] <= ge ? (num_p - sh) : num_p;
                den_reg[k] <= den_p;
                quo_reg[k] <= {quo_p[QOW-2:0], ge};
            end
        end
    end

    assign quo_out = quo_reg[QOW-1];

endmodule

>>> hdl/quaternion_product_normalized_unit.sv
// ----------------------------------------------------------------------------
// quaternion_product_normalized_unit
// Hamilton product of two quaternions, renormalized to unit length unless its norm is near zero.
//
//  channel  dir  handshake                 payload
//  -------  ---  ------------------------  ---------------------------------
//  s_*      in   s_tvalid / s_tready       s_tdata: a_w a_x a_y a_z b_w..b_z
//  m_*      out  m_tvalid / m_tready       m_tdata: r_w r_x r_y r_z
//                                          m_tuser: near_zero_norm
//  cfg_*    in   cfg_valid / cfg_ready     cfg_data: norm_epsilon
//
//  One beat is taken every cycle while the output buffer is not full. The
//  depth is four arithmetic stages, DW square root stages, one divider setup
//  stage, QOW divider stages, an output stage and the output buffer.
//  The square root and divider pipelines, one bit per stage, set the depth.
//  Reset clears the valid bits, empties the output buffer and sets norm_epsilon to 16.
//  A stalled output fills a two-entry buffer; only when it is full does the
//  whole pipeline hold, so nothing is lost or repeated.
//
module quaternion_product_normalized_unit #(
    parameter int FRAC_BITS  = qpn_pkg::FRAC_BITS_DEF,
    parameter int COMP_WIDTH = qpn_pkg::COMP_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from the lowest bit up
    input  logic [8*COMP_WIDTH-1:0]              s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // r_w, r_x, r_y, r_z from the lowest bit up, zero padded to whole bytes
    output logic [((4*COMP_WIDTH+7)/8)*8-1:0]    m_tdata,
    // near_zero_norm
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [qpn_pkg::EPS_WIDTH-1:0]        cfg_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready
);

    import qpn_pkg::*;

    localparam int CW   = COMP_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int G    = NORM_GUARD;
    localparam int OTW  = ((4*CW+7)/8)*8;
    localparam int PRW  = 2*CW;            // one partial product
    localparam int PW   = 2*CW + 2;        // sum of four products
    localparam int QMW  = PW - F + 1;      // rounded product magnitude
    localparam int SQW  = 2*QMW;           // one square
    localparam int SW   = SQW + 2;         // sum of squares
    localparam int DW   = (SW + 2*G + 1) / 2;
    localparam int RWE  = 2*DW;
    localparam int LW   = EPS_WIDTH + F;
    localparam int LSW  = 2*LW;
    localparam int CMPW = (SW > LSW) ? SW : LSW;
    localparam int DENW = DW + 1;
    localparam int QOW  = F + 2;
    localparam int NUMW = DENW + QOW;
    localparam int SATW = ((QMW > QOW) ? QMW : QOW) + 2;
    localparam int SDN  = DW + QOW + 4;
    localparam int NS   = DW + QOW + 6;
    localparam int SQ_LAST = DW + 3;       // valid index of the last root stage

    localparam logic signed [SATW-1:0] SAT_HI = SATW'((64'sd1 <<< (CW-1)) - 64'sd1);
    localparam logic signed [SATW-1:0] SAT_LO = -SAT_HI - SATW'(1);

    typedef struct packed {
        logic [3:0][QMW-1:0] mag;
        logic [3:0]          neg;
        logic                nz;
    } side_t;

    typedef struct packed {
        logic [3:0][CW-1:0] comp;
        logic               nz;
    } out_t;

    function automatic logic [CW-1:0] sat(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] c;
        c = v;
        if (v > SAT_HI)
            c = SAT_HI;
        if (v < SAT_LO)
            c = SAT_LO;
        return c[CW-1:0];
    endfunction

    // ---------------- configuration
    logic [EPS_WIDTH-1:0] eps_reg;
    logic [LSW-1:0]       lim_sq_reg;
    logic [LSW-1:0]       lim_sq_next;

    assign cfg_ready   = 1'b1;
    assign lim_sq_next = (LSW'(eps_reg) * LSW'(eps_reg)) << (2*F);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg    <= EPS_WIDTH'(EPS_RESET);
            lim_sq_reg <= (LSW'(EPS_RESET) * LSW'(EPS_RESET)) << (2*F);
        end
        else
        begin
            if (cfg_valid)
                eps_reg <= cfg_data;
            // follow the register with the threshold in the next cycle
            lim_sq_reg <= lim_sq_next;
        end
    end

    // ---------------- flow control
    logic          en;
    logic [NS-1:0] vld_reg;
    logic [1:0]    cnt_reg;

    // advance the whole pipeline unless the output buffer is full
    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
    end

    // ---------------- stage 0: partial products
    logic signed [CW-1:0]  a_c [4];
    logic signed [CW-1:0]  b_c [4];
    logic signed [PRW-1:0] pr_reg [16];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a_c[i] = s_tdata[i*CW +: CW];
            b_c[i] = s_tdata[(i+4)*CW +: CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    pr_reg[i*4+j] <= a_c[i] * b_c[j];
    end

    // ---------------- stage 1: sum and round to FRAC_BITS
    logic signed [PW-1:0] psum [4];
    side_t                q1;

    always_comb
    begin
        logic [PW-1:0] pmag;
        logic [PW-1:0] rnd;
        psum[0] = pr_reg[0] - pr_reg[5] - pr_reg[10] - pr_reg[15];
        psum[1] = pr_reg[1] + pr_reg[4] + pr_reg[11] - pr_reg[14];
        psum[2] = pr_reg[2] - pr_reg[7] + pr_reg[8] + pr_reg[13];
        psum[3] = pr_reg[3] + pr_reg[6] - pr_reg[9] + pr_reg[12];
        q1 = '0;
        for (int i = 0; i < 4; i++)
        begin
            pmag = psum[i][PW-1] ? PW'(-psum[i]) : PW'(psum[i]);
            // half away from zero on the magnitude
            rnd = (pmag + (PW'(1) << (F-1))) >> F;
            q1.mag[i] = rnd[QMW-1:0];
            q1.neg[i] = psum[i][PW-1];
        end
    end

    // ---------------- stages 2 and 3: squares, sum of squares, threshold
    side_t            sd_reg [SDN];
    side_t            sd2_c;
    logic [SQW-1:0]   sq_reg [4];
    logic [SW-1:0]    s_reg;
    logic [SW-1:0]    s_sum;
    logic             nz_c;

    assign s_sum = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
    assign nz_c  = (CMPW'(s_sum) <= CMPW'(lim_sq_reg));

    // attach the small-norm flag as the item moves into the third side stage
    always_comb
    begin
        sd2_c    = sd_reg[1];
        sd2_c.nz = nz_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= q1;
            for (int k = 1; k < SDN; k++)
                sd_reg[k] <= (k == 2) ? sd2_c : sd_reg[k-1];
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= SQW'(sd_reg[0].mag[i]) * SQW'(sd_reg[0].mag[i]);
            s_reg <= s_sum;
        end
    end

    // ---------------- square root of the guarded sum
    logic [DW-1:0] root;

    qpn_isqrt #(
        .DW (DW)
    ) u_isqrt (
        .clk      (clk),
        .en       (en),
        .n_in     (RWE'(s_reg) << (2*G)),
        .root_out (root)
    );

    // ---------------- divider setup
    logic [DW-1:0]   d_c;
    logic [NUMW-1:0] num_reg [4];
    logic [DENW-1:0] den_reg;

    assign d_c = (root == '0) ? DW'(1) : root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= {d_c, 1'b0};
            for (int i = 0; i < 4; i++)
                num_reg[i] <= (NUMW'(sd_reg[DW+2].mag[i]) << (F+G+1)) + NUMW'(d_c);
        end
    end

    // ---------------- four divider lanes
    logic [QOW-1:0] quo [4];

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        qpn_divide #(
            .NUMW (NUMW),
            .DENW (DENW),
            .QOW  (QOW)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .num_in  (num_reg[i]),
            .den_in  (den_reg),
            .quo_out (quo[i])
        );
    end

    // ---------------- output stage: sign, saturate, select
    out_t out_c;
    out_t out_reg;

    always_comb
    begin
        logic signed [SATW-1:0] v;
        out_c.nz = sd_reg[SDN-1].nz;
        for (int i = 0; i < 4; i++)
        begin
            if (sd_reg[SDN-1].nz)
                v = SATW'(sd_reg[SDN-1].mag[i]);
            else
                v = SATW'(quo[i]);
            if (sd_reg[SDN-1].neg[i])
                v = -v;
            out_c.comp[i] = sat(v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_c;
    end

    // ---------------- output buffer, two entries
    out_t fifo_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic push;
    logic pop;

    assign push = en && vld_reg[NS-1];
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= out_reg;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = OTW'(fifo_reg[rd_ptr_reg].comp);
    assign m_tuser  = fifo_reg[rd_ptr_reg].nz;

    // ---------------- checks
    `include "quaternion_product_normalized_unit_assert.svh"

    // an empty output buffer never holds the input back
    `QPN_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")
    // the threshold tracks the epsilon register
    `QPN_ASSERT_NXT(a_lim_tracks_eps, 1'b1,
        lim_sq_reg == (LSW'($past(eps_reg)) * LSW'($past(eps_reg))) << (2*F),
        "threshold out of step with epsilon")
    // a product above the threshold never yields a zero norm
    `QPN_ASSERT_IMP(a_norm_nonzero, vld_reg[SQ_LAST] && !sd_reg[DW+2].nz, root != '0,
        "zero norm on the normalizing path")
    // the buffer never overflows
    `QPN_ASSERT_IMP(a_no_overflow, cnt_reg == 2'd2, !push, "output buffer overflow")

endmodule
